// File: hw/rtl/phmf_pkg.sv
// Shared types and constants for the prefix histogram match fraction block.
// No dependencies; used by phmf_dp, phmf_ctrl and the top level.
`timescale 1ns / 1ps
package phmf_pkg;

   localparam int MAX_CONSIDERED_DEF = 1024;
   localparam int HIST_LIMIT_DEF     = 16384;
   localparam int ACC_FRAC_BITS_DEF  = 48;

   // configuration register indexes
   localparam logic [2:0] CSR_QUERY_ADDR_HI  = 3'd0;
   localparam logic [2:0] CSR_QUERY_ADDR_LO  = 3'd1;
   localparam logic [2:0] CSR_QUERY_PFX_LEN  = 3'd2;
   localparam logic [2:0] CSR_QUERY_IS_V6    = 3'd3;
   localparam logic [2:0] CSR_OP_CODE        = 3'd4;
   localparam logic [2:0] CSR_HIST_COUNT     = 3'd5;

   // test operations, histogram element on the left
   localparam logic signed [2:0] OP_SUP   = -3'sd2;
   localparam logic signed [2:0] OP_SUPEQ = -3'sd1;
   localparam logic signed [2:0] OP_OVL   = 3'sd0;
   localparam logic signed [2:0] OP_SUBEQ = 3'sd1;
   localparam logic signed [2:0] OP_SUB   = 3'sd2;

   localparam logic [7:0] V4_MAX_LEN = 8'd32;
   localparam logic [7:0] V6_MAX_LEN = 8'd128;

   typedef struct packed {
      logic [63:0] bound_addr_hi;
      logic [63:0] bound_addr_lo;
      logic [7:0]  bound_prefix_len;
      logic        bound_is_v6;
   } req_type;

   typedef struct packed {
      logic [32:0] match_fraction;
      logic [10:0] buckets_counted;
   } rsp_type;

   typedef struct packed {
      logic load;        // take the accepted element
      logic scan_step;   // one byte of the leading-zero scan
      logic eval;        // score element, update bucket state
      logic div_start;   // kick the match/buckets divider
      logic k_load;      // latch step size
      logic advance;     // bump element index
      logic emit;        // load result register, restart stream
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic first;
      logic last;
      logic div_busy;
      logic bkt_zero;
      logic rsp_free;
   } sts_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_FDIV  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

endpackage

// File: hw/rtl/phmf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by phmf_dp.
`timescale 1ns / 1ps
module phmf_div #(
   parameter int NW = 59,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [NW-1:0] quotient
);
   localparam int CNT_W = $clog2(NW + 1);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// File: hw/rtl/phmf_dp.sv
// Datapath: config registers, element scoring, accumulator, counters, result register.
// Depends on phmf_pkg and phmf_div.
`timescale 1ns / 1ps
module phmf_dp #(
   parameter int MAX_CONSIDERED = phmf_pkg::MAX_CONSIDERED_DEF,
   parameter int HIST_LIMIT     = phmf_pkg::HIST_LIMIT_DEF,
   parameter int ACC_FRAC_BITS  = phmf_pkg::ACC_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  phmf_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output phmf_pkg::rsp_type rsp_data,
   input  phmf_pkg::cmd_type cmd,
   output phmf_pkg::sts_type sts
);
   localparam int IDX_W = $clog2(HIST_LIMIT) + 1;
   localparam int CW    = (IDX_W > 15) ? IDX_W : 15;
   localparam int BKT_W = $clog2(MAX_CONSIDERED + 1);
   localparam int ACC_W = ACC_FRAC_BITS + BKT_W;
   localparam int SH_R  = (ACC_FRAC_BITS >= 32) ? ACC_FRAC_BITS - 32 : 0;
   localparam int SH_L  = (ACC_FRAC_BITS >= 32) ? 0 : 32 - ACC_FRAC_BITS;
   // reciprocal of MAX_CONSIDERED, exact for every numerator below 2^IDX_W
   localparam int DIV_SH = IDX_W + $clog2(MAX_CONSIDERED);
   localparam int KP_W   = 2 * IDX_W + 1;
   localparam longint K_RECIP = ((longint'(1) << DIV_SH) + longint'(MAX_CONSIDERED) - 1)
                                / longint'(MAX_CONSIDERED);

   function automatic logic [3:0] lz8(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) n = 4'(7 - i);
      end
      return n;
   endfunction

   // configuration
   logic [63:0]       qhi_ff, qlo_ff;
   logic [7:0]        qlen_ff;
   logic              qv6_ff;
   logic signed [2:0] op_ff;
   logic [14:0]       hcnt_ff;
   logic signed [2:0] wop;

   // current element
   logic [127:0] cur_ff, x_ff;
   logic [7:0]   cur_len_ff, common_ff;
   logic         cur_v6_ff;
   logic [3:0]   scan_ff;

   // stream state
   logic signed [1:0] prev_ord_ff;
   logic [7:0]        prev_div_ff;
   logic              prev_ok_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [BKT_W-1:0]  bkt_ff;
   logic [IDX_W-1:0]  idx_ff, next_ff, k_ff;
   logic              rsp_valid_ff;
   phmf_pkg::rsp_type rsp_ff;

   logic [7:0]        in_len, qlen_s, minb, cmin, dec, dval, dmax;
   logic [7:0]        top;
   logic              v6diff, ebit, dok, taken;
   logic signed [1:0] mlc, ord;
   logic signed [8:0] dlen;
   logic [ACC_W-1:0]  add;
   logic [CW-1:0]     hc_ext;
   logic [IDX_W-1:0]  cnt;
   logic [IDX_W-1:0]  k_num, k_quo;
   logic [KP_W-1:0]   k_prod;
   logic [ACC_W-1:0]  quo;
   logic              div_busy;
   logic [ACC_W+32:0] wide;
   logic [BKT_W+10:0] bkt_ext;

   // saturate prefix lengths
   always_comb begin
      in_len = req_data.bound_prefix_len;
      if (req_data.bound_is_v6) begin
         if (in_len > phmf_pkg::V6_MAX_LEN) in_len = phmf_pkg::V6_MAX_LEN;
      end else begin
         if (in_len > phmf_pkg::V4_MAX_LEN) in_len = phmf_pkg::V4_MAX_LEN;
      end
      qlen_s = qlen_ff;
      if (qv6_ff) begin
         if (qlen_s > phmf_pkg::V6_MAX_LEN) qlen_s = phmf_pkg::V6_MAX_LEN;
      end else begin
         if (qlen_s > phmf_pkg::V4_MAX_LEN) qlen_s = phmf_pkg::V4_MAX_LEN;
      end
   end

   // element count, clamped to 1..HIST_LIMIT
   always_comb begin
      hc_ext = CW'(hcnt_ff);
      if (hc_ext > CW'(HIST_LIMIT)) cnt = IDX_W'(HIST_LIMIT);
      else if (hc_ext == '0)        cnt = IDX_W'(1);
      else                          cnt = IDX_W'(hc_ext);
   end

   // step size numerator; (count-2)/MAX_CONSIDERED by reciprocal multiply
   assign k_num  = (cnt >= IDX_W'(2)) ? cnt - IDX_W'(2) : '0;
   assign k_prod = KP_W'(k_num) * KP_W'(K_RECIP);
   assign k_quo  = IDX_W'(k_prod >> DIV_SH);

   // scoring of the current element against the query
   always_comb begin
      v6diff = cur_v6_ff != qv6_ff;
      minb   = (cur_len_ff < qlen_s) ? cur_len_ff : qlen_s;
      cmin   = (common_ff < minb) ? common_ff : minb;
      dlen   = $signed({1'b0, cur_len_ff}) - $signed({1'b0, qlen_s});
      if ((dlen > 0 && op_ff >= phmf_pkg::OP_OVL) ||
          (dlen == 0 && op_ff >= phmf_pkg::OP_SUPEQ && op_ff <= phmf_pkg::OP_SUBEQ) ||
          (dlen < 0 && op_ff <= phmf_pkg::OP_OVL)) begin
         mlc = 2'sd0;
      end else begin
         mlc = (op_ff > phmf_pkg::OP_OVL) ? 2'sd1 : -2'sd1;
      end
      ebit = cur_ff[7'(7'd127 - common_ff[6:0])];
      if (v6diff)                ord = cur_v6_ff ? 2'sd1 : -2'sd1;
      else if (common_ff < minb) ord = ebit ? 2'sd1 : -2'sd1;
      else                       ord = mlc;
      if (op_ff < phmf_pkg::OP_OVL)      dec = cur_len_ff;
      else if (op_ff > phmf_pkg::OP_OVL) dec = qlen_s;
      else                               dec = minb;
      dval = dec - cmin;
      dok  = !v6diff && (mlc == 2'sd0);

      // bucket contribution
      add  = '0;
      dmax = '0;
      if (prev_ord_ff == 2'sd0 && ord == 2'sd0) begin
         add = ACC_W'(1) << ACC_FRAC_BITS;
      end else if ((prev_ord_ff <= 2'sd0 && ord >= 2'sd0) ||
                   (prev_ord_ff >= 2'sd0 && ord <= 2'sd0)) begin
         if (prev_ok_ff && dok) dmax = (prev_div_ff > dval) ? prev_div_ff : dval;
         else if (prev_ok_ff)   dmax = prev_div_ff;
         else                   dmax = dval;
         if ((prev_ok_ff || dok) && dmax <= 8'(ACC_FRAC_BITS)) begin
            add = ACC_W'(1) << (8'(ACC_FRAC_BITS) - dmax);
         end
      end
   end

   assign taken = idx_ff == next_ff;
   assign top   = x_ff[127:120];

   // match/buckets at the end of the histogram
   phmf_div #(.NW(ACC_W), .DW(BKT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (bkt_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign wide    = ((ACC_W + 33)'(quo) >> SH_R) << SH_L;
   assign bkt_ext = (BKT_W + 11)'(bkt_ff);
   assign wop     = $signed(csr_wdata[2:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         qhi_ff       <= '0;
         qlo_ff       <= '0;
         qlen_ff      <= '0;
         qv6_ff       <= 1'b0;
         op_ff        <= phmf_pkg::OP_OVL;
         hcnt_ff      <= '0;
         prev_ord_ff  <= 2'sd0;
         prev_div_ff  <= '0;
         prev_ok_ff   <= 1'b0;
         acc_ff       <= '0;
         bkt_ff       <= '0;
         idx_ff       <= '0;
         next_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit)                        rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.eval) begin
            if (idx_ff == '0 || taken) begin
               prev_ord_ff <= ord;
               prev_div_ff <= dval;
               prev_ok_ff  <= dok;
            end
            if (idx_ff != '0 && taken) begin
               acc_ff  <= acc_ff + add;
               bkt_ff  <= bkt_ff + 1'b1;
               next_ff <= next_ff + k_ff;
            end
         end
         if (cmd.k_load) begin
            k_ff    <= k_quo + 1'b1;
            next_ff <= k_quo + 1'b1;
         end
         if (cmd.advance) idx_ff <= idx_ff + 1'b1;
         if (cmd.emit || csr_we) begin
            prev_ord_ff <= 2'sd0;
            prev_div_ff <= '0;
            prev_ok_ff  <= 1'b0;
            acc_ff      <= '0;
            bkt_ff      <= '0;
            idx_ff      <= '0;
            next_ff     <= '0;
         end
         if (csr_we) begin
            case (csr_index)
               phmf_pkg::CSR_QUERY_ADDR_HI: qhi_ff  <= csr_wdata;
               phmf_pkg::CSR_QUERY_ADDR_LO: qlo_ff  <= csr_wdata;
               phmf_pkg::CSR_QUERY_PFX_LEN: qlen_ff <= csr_wdata[7:0];
               phmf_pkg::CSR_QUERY_IS_V6:   qv6_ff  <= csr_wdata[0];
               phmf_pkg::CSR_OP_CODE: begin
                  if (wop < phmf_pkg::OP_SUP)      op_ff <= phmf_pkg::OP_SUP;
                  else if (wop > phmf_pkg::OP_SUB) op_ff <= phmf_pkg::OP_SUB;
                  else                             op_ff <= wop;
               end
               phmf_pkg::CSR_HIST_COUNT:    hcnt_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   // element registers, leading-zero scan and result data register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff     <= {req_data.bound_addr_hi, req_data.bound_addr_lo};
         cur_len_ff <= in_len;
         cur_v6_ff  <= req_data.bound_is_v6;
         x_ff       <= {req_data.bound_addr_hi, req_data.bound_addr_lo} ^ {qhi_ff, qlo_ff};
         scan_ff    <= '0;
      end else if (cmd.scan_step) begin
         if (sts.scan_done) begin
            common_ff <= {1'b0, scan_ff, 3'b000} + {4'b0000, lz8(top)};
         end else begin
            x_ff    <= {x_ff[119:0], 8'h00};
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         rsp_ff.match_fraction  <= (bkt_ff == '0) ? 33'd0 : wide[32:0];
         rsp_ff.buckets_counted <= bkt_ext[10:0];
      end
   end

   assign sts.scan_done = (top != 8'h00) || (scan_ff == 4'd15);
   assign sts.first     = idx_ff == '0;
   assign sts.last      = idx_ff >= cnt - 1'b1;
   assign sts.div_busy  = div_busy;
   assign sts.bkt_zero  = bkt_ff == '0;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: hw/rtl/phmf_ctrl.sv
// Controller state machine: sequences scan, scoring, final division and result transfer.
// Depends on phmf_pkg.
`timescale 1ns / 1ps
module phmf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  phmf_pkg::sts_type sts,
   output phmf_pkg::cmd_type cmd
);
   phmf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         phmf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = phmf_pkg::ST_SCAN;
            end
         end
         phmf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = phmf_pkg::ST_EVAL;
         end
         phmf_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.first) cmd.k_load = 1'b1;
            state_in = phmf_pkg::ST_CHECK;
         end
         phmf_pkg::ST_CHECK: begin
            if (!sts.last) begin
               cmd.advance = 1'b1;
               state_in    = phmf_pkg::ST_IDLE;
            end else if (sts.bkt_zero) begin
               state_in = phmf_pkg::ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = phmf_pkg::ST_FDIV;
            end
         end
         phmf_pkg::ST_FDIV: begin
            if (!sts.div_busy) state_in = phmf_pkg::ST_EMIT;
         end
         phmf_pkg::ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = phmf_pkg::ST_IDLE;
            end
         end
         default: state_in = phmf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= phmf_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// File: hw/rtl/prefix_histogram_match_fraction.sv
// Top level: estimates the fraction of histogram buckets matching a query prefix.
// Per element: an accept state, a byte-wise scan that stops at the first differing leading
// address byte or at the last byte, a scoring state and a check state; one element at a time.
// Last element: a final division over ACC_W quotient bits (ACC_W = ACC_FRAC_BITS + 11 by default,
// skipped with no buckets), then the emit state loads the result, held while a result is stalled.
// Reset: synchronous, clears config and stream state.
`timescale 1ns / 1ps
module prefix_histogram_match_fraction #(
   parameter int MAX_CONSIDERED = phmf_pkg::MAX_CONSIDERED_DEF,
   parameter int HIST_LIMIT     = phmf_pkg::HIST_LIMIT_DEF,
   parameter int ACC_FRAC_BITS  = phmf_pkg::ACC_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // element input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  phmf_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output phmf_pkg::rsp_type rsp_data,
   // configuration writes; any write restarts the histogram stream
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   phmf_pkg::cmd_type cmd;
   phmf_pkg::sts_type sts;

   // sequencing only; all arithmetic lives in the datapath
   phmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // scoring, accumulator, divider and the result register
   phmf_dp #(
      .MAX_CONSIDERED (MAX_CONSIDERED),
      .HIST_LIMIT     (HIST_LIMIT),
      .ACC_FRAC_BITS  (ACC_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // an accepted element keeps the block busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken back to back");

   // the fraction never exceeds 1.0
   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.match_fraction[32] && (|rsp_data.match_fraction[31:0])))
      else $error("fraction above one");

   // no buckets means a zero fraction
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.buckets_counted == 11'd0) |-> rsp_data.match_fraction == 33'd0)
      else $error("nonzero fraction without buckets");
endmodule
